// ----- rtl/rcls_pkg.sv -----
// Shared types, constants and slot tables for the line sensor steering block.
package rcls_pkg;

   // Sensor array and counter sizing
   localparam int SENSOR_COUNT      = 9;
   localparam int COUNT_WIDTH_DEF   = 8;
   localparam int SLOT_WIDTH        = 4;
   localparam int DUTY_WIDTH        = 7;
   localparam int DIR_WIDTH         = 2;
   localparam int THRESHOLD_WIDTH   = 8;
   localparam int CHARGE_WIDTH      = 4;

   // Motor direction codes
   localparam logic [DIR_WIDTH-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_WIDTH-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_WIDTH-1:0] DIR_BACK = 2'd2;
   localparam logic [DIR_WIDTH-1:0] DIR_NONE = 2'd3;

   // Commanded speeds of the steering rules
   localparam logic [DUTY_WIDTH-1:0] SPEED_CENTER = 7'd15;
   localparam logic [DUTY_WIDTH-1:0] SPEED_FAST   = 7'd20;
   localparam logic [DUTY_WIDTH-1:0] SPEED_SLOW   = 7'd10;
   localparam logic [DUTY_WIDTH-1:0] SPEED_TURN   = 7'd25;
   localparam logic [DUTY_WIDTH-1:0] SPEED_CREEP  = 7'd2;
   localparam logic [DUTY_WIDTH-1:0] SPEED_BACK   = 7'd30;

   // Scan slots
   localparam logic [SLOT_WIDTH-1:0] SLOT_FIRST  = 4'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SKIP_A = 4'd5;
   localparam logic [SLOT_WIDTH-1:0] SLOT_SKIP_B = 4'd6;
   localparam logic [SLOT_WIDTH-1:0] SLOT_LAST   = 4'd8;

   // Register map
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_CHARGE    = 3'd1;
   localparam logic [2:0] CSR_OFFSET    = 3'd2;
   localparam logic [2:0] CSR_LIMIT     = 3'd3;
   localparam logic [2:0] CSR_CLAMP     = 3'd4;

   // Register reset values
   localparam logic [THRESHOLD_WIDTH-1:0] RST_THRESHOLD = 8'd15;
   localparam logic [CHARGE_WIDTH-1:0]    RST_CHARGE    = 4'd2;
   localparam logic [DUTY_WIDTH-1:0]      RST_OFFSET    = 7'd25;
   localparam logic [DUTY_WIDTH-1:0]      RST_LIMIT     = 7'd95;
   localparam logic [DUTY_WIDTH-1:0]      RST_CLAMP     = 7'd70;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] black_threshold;
      logic [CHARGE_WIDTH-1:0]    charge_ticks;
      logic [DUTY_WIDTH-1:0]      duty_offset;
      logic [DUTY_WIDTH-1:0]      duty_limit;
      logic [DUTY_WIDTH-1:0]      duty_clamp;
   } cfg_type;

   typedef struct packed {
      logic [DIR_WIDTH-1:0]  left_dir;
      logic [DIR_WIDTH-1:0]  right_dir;
      logic [DUTY_WIDTH-1:0] left_duty;
      logic [DUTY_WIDTH-1:0] right_duty;
   } motor_type;

   // Result word, lowest field last so the packing matches tdata
   typedef struct packed {
      logic                    scan_busy;
      logic [DUTY_WIDTH-1:0]   right_duty;
      logic [DUTY_WIDTH-1:0]   left_duty;
      logic [DIR_WIDTH-1:0]    right_dir;
      logic [DIR_WIDTH-1:0]    left_dir;
      logic [SENSOR_COUNT-1:0] sensor_bits;
      logic                    line_drive;
   } result_type;

   // Input line read in a slot
   function automatic logic [SLOT_WIDTH-1:0] slot_pin(input logic [SLOT_WIDTH-1:0] s);
      case (s)
         4'd0:    slot_pin = 4'd0;
         4'd1:    slot_pin = 4'd2;
         4'd2:    slot_pin = 4'd1;
         4'd3:    slot_pin = 4'd5;
         4'd4:    slot_pin = 4'd6;
         4'd5:    slot_pin = 4'd3;
         4'd6:    slot_pin = 4'd8;
         4'd7:    slot_pin = 4'd4;
         4'd8:    slot_pin = 4'd7;
         default: slot_pin = 4'd0;
      endcase
   endfunction

   // Sensor position written in a slot
   function automatic logic [SLOT_WIDTH-1:0] slot_pos(input logic [SLOT_WIDTH-1:0] s);
      case (s)
         4'd0:    slot_pos = 4'd4;
         4'd1:    slot_pos = 4'd3;
         4'd2:    slot_pos = 4'd5;
         4'd3:    slot_pos = 4'd2;
         4'd4:    slot_pos = 4'd6;
         4'd5:    slot_pos = 4'd1;
         4'd6:    slot_pos = 4'd7;
         4'd7:    slot_pos = 4'd0;
         4'd8:    slot_pos = 4'd8;
         default: slot_pos = 4'd0;
      endcase
   endfunction

   // Slot that follows a slot
   function automatic logic [SLOT_WIDTH-1:0] slot_next(input logic [SLOT_WIDTH-1:0] s);
      case (s)
         4'd0:    slot_next = 4'd1;
         4'd1:    slot_next = 4'd2;
         4'd2:    slot_next = 4'd3;
         4'd3:    slot_next = 4'd4;
         4'd4:    slot_next = 4'd7;
         4'd5:    slot_next = 4'd6;
         4'd6:    slot_next = 4'd7;
         4'd7:    slot_next = 4'd8;
         4'd8:    slot_next = 4'd0;
         default: slot_next = 4'd0;
      endcase
   endfunction

endpackage

// ----- rtl/rc_line_sensor_steering.sv -----
// Top level of the line sensor steering block: stream ports, staging and registers.
//
// Usage:
//   req_*  input word stream. req_tuser is the tick kind (0 measure, 1 sample),
//          req_tdata carries the nine current sensor line levels.
//   rsp_*  one result word per input word, in order: line drive, black bits,
//          motor directions and duties, scan busy flag.
//   csr_*  APB-style register port, registers at byte addresses 0,4,..,16;
//          write only while the stream is idle.
// Path: an accepted word is held in the input register, processed in one
//   pass of the scan and steering logic, and its result is registered in
//   the result register once that is free, then shown on rsp_tdata.
// Throughput: one word per cycle while rsp_tready is high, set by the single
//   pass between the input register and the result register.
// Reset: clears the scan state, stops the left motor, sets the right motor
//   forward with zero duties and loads the register defaults.
// Stall: while rsp_tready is low the result is held; the input register still
//   takes one more word, then req_tready drops until the result is taken.
module rc_line_sensor_steering #(
   parameter int COUNT_WIDTH = rcls_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [8:0] line_levels
   input  logic                                req_tuser,  // [0] func
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] line_drive, [9:1] sensor_bits, [11:10] left_dir, [13:12] right_dir,
   // [20:14] left_duty, [27:21] right_duty, [28] scan_busy
   output logic [31:0]                         rsp_tdata,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcls_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   rcls_pkg::cfg_type                 cfg;
   rcls_pkg::result_type              result_in;
   rcls_pkg::result_type              rsp_data_ff;

   logic                              in_valid_ff, in_valid_in;
   logic                              in_func_ff;
   logic [rcls_pkg::SENSOR_COUNT-1:0] in_levels_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              req_accept;
   logic                              advance;

   rcls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rcls_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_func   (in_func_ff),
      .step_levels (in_levels_ff),
      .cfg         (cfg),
      .result_in   (result_in)
   );

   // Handshake: process the held word when the result slot is free
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff   <= req_tuser;
         in_levels_ff <= req_tdata[rcls_pkg::SENSOR_COUNT-1:0];
      end
   end

   // Hold the result word
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

endmodule

// ----- rtl/rcls_csr.sv -----
// Configuration register file with an APB-style write and read port.
module rcls_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rcls_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [rcls_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [rcls_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output rcls_pkg::cfg_type                   cfg
);

   rcls_pkg::cfg_type cfg_ff;
   rcls_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[4:2];
   assign cfg       = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            rcls_pkg::CSR_THRESHOLD: cfg_in.black_threshold = pwdata[7:0];
            rcls_pkg::CSR_CHARGE:    cfg_in.charge_ticks    = pwdata[3:0];
            rcls_pkg::CSR_OFFSET:    cfg_in.duty_offset     = pwdata[6:0];
            rcls_pkg::CSR_LIMIT:     cfg_in.duty_limit      = pwdata[6:0];
            rcls_pkg::CSR_CLAMP:     cfg_in.duty_clamp      = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_threshold <= rcls_pkg::RST_THRESHOLD;
         cfg_ff.charge_ticks    <= rcls_pkg::RST_CHARGE;
         cfg_ff.duty_offset     <= rcls_pkg::RST_OFFSET;
         cfg_ff.duty_limit      <= rcls_pkg::RST_LIMIT;
         cfg_ff.duty_clamp      <= rcls_pkg::RST_CLAMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         rcls_pkg::CSR_THRESHOLD: prdata = {24'd0, cfg_ff.black_threshold};
         rcls_pkg::CSR_CHARGE:    prdata = {28'd0, cfg_ff.charge_ticks};
         rcls_pkg::CSR_OFFSET:    prdata = {25'd0, cfg_ff.duty_offset};
         rcls_pkg::CSR_LIMIT:     prdata = {25'd0, cfg_ff.duty_limit};
         rcls_pkg::CSR_CLAMP:     prdata = {25'd0, cfg_ff.duty_clamp};
         default:                 prdata = '0;
      endcase
   end

endmodule

// ----- rtl/rcls_steer.sv -----
// Priority steering rules: motor directions and duties from the black bits.
module rcls_steer (
   input  logic [rcls_pkg::SENSOR_COUNT-1:0] black_bits,
   input  rcls_pkg::motor_type               motor_cur,
   input  rcls_pkg::cfg_type                 cfg,
   output rcls_pkg::motor_type               motor_next
);

   // Offset the speed, clamp above the limit
   function automatic logic [rcls_pkg::DUTY_WIDTH-1:0] duty_of(
      input logic [rcls_pkg::DUTY_WIDTH-1:0] speed,
      input rcls_pkg::cfg_type               c
   );
      logic [rcls_pkg::DUTY_WIDTH:0] sum;
      sum = {1'b0, speed} + {1'b0, c.duty_offset};
      if (sum > {1'b0, c.duty_limit}) begin
         duty_of = c.duty_clamp;
      end else begin
         duty_of = sum[rcls_pkg::DUTY_WIDTH-1:0];
      end
   endfunction

   logic [rcls_pkg::DUTY_WIDTH-1:0] left_speed;
   logic [rcls_pkg::DUTY_WIDTH-1:0] right_speed;
   logic                            rule_hit;

   // Pick the first matching rule
   always_comb begin
      motor_next  = motor_cur;
      left_speed  = rcls_pkg::SPEED_CENTER;
      right_speed = rcls_pkg::SPEED_CENTER;
      rule_hit    = 1'b1;
      if (black_bits[4] && !(black_bits[3] || black_bits[5])) begin
         motor_next.left_dir  = rcls_pkg::DIR_FWD;
         motor_next.right_dir = rcls_pkg::DIR_FWD;
      end else if (black_bits[3] && !black_bits[8]) begin
         motor_next.left_dir  = rcls_pkg::DIR_FWD;
         motor_next.right_dir = rcls_pkg::DIR_FWD;
         left_speed  = rcls_pkg::SPEED_FAST;
         right_speed = rcls_pkg::SPEED_SLOW;
      end else if (black_bits[5] && !black_bits[0]) begin
         motor_next.left_dir  = rcls_pkg::DIR_FWD;
         motor_next.right_dir = rcls_pkg::DIR_FWD;
         left_speed  = rcls_pkg::SPEED_SLOW;
         right_speed = rcls_pkg::SPEED_FAST;
      end else if (black_bits[2] && !black_bits[8]) begin
         motor_next.left_dir  = rcls_pkg::DIR_FWD;
         motor_next.right_dir = rcls_pkg::DIR_FWD;
         left_speed  = rcls_pkg::SPEED_TURN;
         right_speed = rcls_pkg::SPEED_CREEP;
      end else if (black_bits[6] && !black_bits[0]) begin
         motor_next.left_dir  = rcls_pkg::DIR_FWD;
         motor_next.right_dir = rcls_pkg::DIR_FWD;
         left_speed  = rcls_pkg::SPEED_CREEP;
         right_speed = rcls_pkg::SPEED_TURN;
      end else if (black_bits[0]) begin
         motor_next.left_dir = rcls_pkg::DIR_BACK;
         left_speed  = rcls_pkg::SPEED_FAST;
         right_speed = rcls_pkg::SPEED_BACK;
      end else if (black_bits[8]) begin
         motor_next.right_dir = rcls_pkg::DIR_BACK;
         left_speed  = rcls_pkg::SPEED_BACK;
         right_speed = rcls_pkg::SPEED_FAST;
      end else begin
         rule_hit = 1'b0;
      end
      if (rule_hit) begin
         motor_next.left_duty  = duty_of(left_speed, cfg);
         motor_next.right_duty = duty_of(right_speed, cfg);
      end
   end

endmodule

// ----- rtl/rcls_core.sv -----
// Scan sequencer and steering state, updated once per processed word.
module rcls_core #(
   parameter int COUNT_WIDTH = rcls_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_valid,
   input  logic                              step_func,
   input  logic [rcls_pkg::SENSOR_COUNT-1:0] step_levels,
   input  rcls_pkg::cfg_type                 cfg,
   output rcls_pkg::result_type              result_in
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > rcls_pkg::THRESHOLD_WIDTH) ?
                              COUNT_WIDTH : rcls_pkg::THRESHOLD_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [rcls_pkg::SENSOR_COUNT-1:0] black_ff, black_in;
   logic [rcls_pkg::SLOT_WIDTH-1:0]   slot_ff, slot_in;
   logic [COUNT_WIDTH-1:0]            count_ff, count_in;
   logic                              charge_ff, charge_in;
   logic                              active_ff, active_in;
   rcls_pkg::motor_type               motor_ff, motor_in;
   rcls_pkg::motor_type               motor_steer;

   logic                              charge_step;
   logic [COUNT_WIDTH-1:0]            count_step;
   logic [CMP_WIDTH-1:0]              count_cmp;
   logic [CMP_WIDTH-1:0]              charge_cmp;
   logic [CMP_WIDTH-1:0]              thresh_cmp;
   logic [rcls_pkg::SLOT_WIDTH-1:0]   pin_sel;
   logic [rcls_pkg::SLOT_WIDTH-1:0]   pos_sel;

   rcls_steer u_steer (
      .black_bits (black_ff),
      .motor_cur  (motor_ff),
      .cfg        (cfg),
      .motor_next (motor_steer)
   );

   // Slot lookups and counter step
   assign pin_sel    = rcls_pkg::slot_pin(slot_ff);
   assign pos_sel    = rcls_pkg::slot_pos(slot_ff);
   assign charge_cmp = CMP_WIDTH'(cfg.charge_ticks);
   assign thresh_cmp = CMP_WIDTH'(cfg.black_threshold);
   assign charge_step = (CMP_WIDTH'(count_ff) == charge_cmp) ? 1'b0 : charge_ff;
   assign count_step  = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign count_cmp   = CMP_WIDTH'(count_step);

   // Next state
   always_comb begin
      black_in  = black_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      charge_in = charge_ff;
      active_in = active_ff;
      motor_in  = motor_ff;
      if (step_valid) begin
         if (step_func) begin
            // Sample tick: steer from the last scan, then restart it
            motor_in  = motor_steer;
            charge_in = 1'b1;
            count_in  = '0;
            slot_in   = rcls_pkg::SLOT_FIRST;
            active_in = 1'b1;
         end else if (active_ff) begin
            if (slot_ff > rcls_pkg::SLOT_LAST) begin
               active_in = 1'b0;
            end else begin
               charge_in = charge_step;
               count_in  = count_step;
               // Line discharged: record the bit and move on
               if (!(count_cmp <= charge_cmp) && !charge_step && !step_levels[pin_sel]) begin
                  black_in[pos_sel] = (count_cmp > thresh_cmp);
                  slot_in = rcls_pkg::slot_next(slot_ff);
                  if (slot_ff == rcls_pkg::SLOT_LAST) begin
                     active_in = 1'b0;
                  end else begin
                     charge_in = 1'b1;
                     count_in  = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff            <= '0;
         slot_ff             <= rcls_pkg::SLOT_FIRST;
         count_ff            <= '0;
         charge_ff           <= 1'b1;
         active_ff           <= 1'b0;
         motor_ff.left_dir   <= rcls_pkg::DIR_STOP;
         motor_ff.right_dir  <= rcls_pkg::DIR_FWD;
         motor_ff.left_duty  <= '0;
         motor_ff.right_duty <= '0;
      end else begin
         black_ff  <= black_in;
         slot_ff   <= slot_in;
         count_ff  <= count_in;
         charge_ff <= charge_in;
         active_ff <= active_in;
         motor_ff  <= motor_in;
      end
   end

   // Result is the state after this word
   assign result_in.line_drive  = charge_in;
   assign result_in.sensor_bits = black_in;
   assign result_in.left_dir    = motor_in.left_dir;
   assign result_in.right_dir   = motor_in.right_dir;
   assign result_in.left_duty   = motor_in.left_duty;
   assign result_in.right_duty  = motor_in.right_duty;
   assign result_in.scan_busy   = active_in;

`ifndef SYNTH
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_func |=> active_ff && charge_ff && count_ff == '0
                                  && slot_ff == rcls_pkg::SLOT_FIRST)
      else $error("scan did not restart on sample tick");
   a_bits_hold: assert property (@(posedge clock) disable iff (reset)
      !step_valid || step_func |=> $stable(black_ff))
      else $error("black bits changed without a measure tick");
   a_slot_skip: assert property (@(posedge clock) disable iff (reset)
      slot_ff != rcls_pkg::SLOT_SKIP_A && slot_ff != rcls_pkg::SLOT_SKIP_B)
      else $error("scan reached a skipped slot");
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      motor_ff.left_dir != rcls_pkg::DIR_NONE && motor_ff.right_dir != rcls_pkg::DIR_NONE)
      else $error("motor direction holds an unused code");
`endif

endmodule

// ----- verif/rcls_steering_checker.sv -----
`timescale 1ns / 100ps
// Status predictor and checker for the line sensor steering block.
module rcls_steering_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [8:0] line_levels
   input  logic                                req_tuser,  // [0] func
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] line_drive, [9:1] sensor_bits, [11:10] left_dir, [13:12] right_dir,
   // [20:14] left_duty, [27:21] right_duty, [28] scan_busy
   input  logic [31:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcls_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count
);

   // Where each scan slot reads, what position it fills and where it goes after
   typedef struct packed {
      logic [rcls_pkg::SLOT_WIDTH-1:0] pin;
      logic [rcls_pkg::SLOT_WIDTH-1:0] pos;
      logic [rcls_pkg::SLOT_WIDTH-1:0] follow;
   } route_type;

   // Predicted block state
   rcls_pkg::cfg_type                    cfg;
   rcls_pkg::motor_type                  motor;
   logic [rcls_pkg::SENSOR_COUNT-1:0]    black;
   logic [rcls_pkg::SLOT_WIDTH-1:0]      slot;
   logic [rcls_pkg::COUNT_WIDTH_DEF-1:0] count;
   logic                                 charging;
   logic                                 scanning;

   rcls_pkg::result_type status_due[$];
   int                   fails = 0;
   int                   checked = 0;

   function automatic route_type route_of(input logic [rcls_pkg::SLOT_WIDTH-1:0] s);
      case (s)
         4'd0:    return {4'd0, 4'd4, 4'd1};
         4'd1:    return {4'd2, 4'd3, 4'd2};
         4'd2:    return {4'd1, 4'd5, 4'd3};
         4'd3:    return {4'd5, 4'd2, 4'd4};
         4'd4:    return {4'd6, 4'd6, 4'd7};
         4'd5:    return {4'd3, 4'd1, 4'd6};
         4'd6:    return {4'd8, 4'd7, 4'd7};
         4'd7:    return {4'd4, 4'd0, 4'd8};
         4'd8:    return {4'd7, 4'd8, 4'd0};
         default: return '0;
      endcase
   endfunction

   // Offset the speed, fall back to the clamp above the limit
   function automatic logic [rcls_pkg::DUTY_WIDTH-1:0] duty_for(
      input logic [rcls_pkg::DUTY_WIDTH-1:0] speed
   );
      logic [rcls_pkg::DUTY_WIDTH:0] sum;
      sum = {1'b0, speed} + {1'b0, cfg.duty_offset};
      return (sum > {1'b0, cfg.duty_limit}) ? cfg.duty_clamp
                                            : sum[rcls_pkg::DUTY_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] register_value(input logic [2:0] idx);
      case (idx)
         rcls_pkg::CSR_THRESHOLD: return 32'(cfg.black_threshold);
         rcls_pkg::CSR_CHARGE:    return 32'(cfg.charge_ticks);
         rcls_pkg::CSR_OFFSET:    return 32'(cfg.duty_offset);
         rcls_pkg::CSR_LIMIT:     return 32'(cfg.duty_limit);
         rcls_pkg::CSR_CLAMP:     return 32'(cfg.duty_clamp);
         default:                 return '0;
      endcase
   endfunction

   task automatic command(input logic [rcls_pkg::DIR_WIDTH-1:0] ldir,
                          input logic [rcls_pkg::DIR_WIDTH-1:0] rdir,
                          input logic [rcls_pkg::DUTY_WIDTH-1:0] lspd,
                          input logic [rcls_pkg::DUTY_WIDTH-1:0] rspd);
      motor.left_dir   = ldir;
      motor.right_dir  = rdir;
      motor.left_duty  = duty_for(lspd);
      motor.right_duty = duty_for(rspd);
   endtask

   // Priority rules on the last scan's black bits; no match keeps the motors
   task automatic apply_steering();
      if (black[4] && !(black[3] || black[5]))
         command(rcls_pkg::DIR_FWD, rcls_pkg::DIR_FWD,
                 rcls_pkg::SPEED_CENTER, rcls_pkg::SPEED_CENTER);
      else if (black[3] && !black[8])
         command(rcls_pkg::DIR_FWD, rcls_pkg::DIR_FWD,
                 rcls_pkg::SPEED_FAST, rcls_pkg::SPEED_SLOW);
      else if (black[5] && !black[0])
         command(rcls_pkg::DIR_FWD, rcls_pkg::DIR_FWD,
                 rcls_pkg::SPEED_SLOW, rcls_pkg::SPEED_FAST);
      else if (black[2] && !black[8])
         command(rcls_pkg::DIR_FWD, rcls_pkg::DIR_FWD,
                 rcls_pkg::SPEED_TURN, rcls_pkg::SPEED_CREEP);
      else if (black[6] && !black[0])
         command(rcls_pkg::DIR_FWD, rcls_pkg::DIR_FWD,
                 rcls_pkg::SPEED_CREEP, rcls_pkg::SPEED_TURN);
      else if (black[0])
         command(rcls_pkg::DIR_BACK, motor.right_dir,
                 rcls_pkg::SPEED_FAST, rcls_pkg::SPEED_BACK);
      else if (black[8])
         command(motor.left_dir, rcls_pkg::DIR_BACK,
                 rcls_pkg::SPEED_BACK, rcls_pkg::SPEED_FAST);
   endtask

   // Advance the discharge count and settle the current slot once its line drops
   task automatic take_measure(input logic [rcls_pkg::SENSOR_COUNT-1:0] levels);
      route_type                       r;
      logic [rcls_pkg::SLOT_WIDTH-1:0] was;
      if (!scanning)
         return;
      if (slot > rcls_pkg::SLOT_LAST) begin
         scanning = 1'b0;
         return;
      end
      if (count == rcls_pkg::COUNT_WIDTH_DEF'(cfg.charge_ticks))
         charging = 1'b0;
      if (count != '1)
         count = count + 1'b1;
      if (count <= rcls_pkg::COUNT_WIDTH_DEF'(cfg.charge_ticks) || charging)
         return;
      was = slot;
      r   = route_of(was);
      if (levels[r.pin])
         return;
      black[r.pos] = (count > cfg.black_threshold);
      slot = r.follow;
      if (was == rcls_pkg::SLOT_LAST) begin
         scanning = 1'b0;
      end else begin
         charging = 1'b1;
         count    = '0;
      end
   endtask

   task automatic step_steering(input logic sample,
                                input logic [rcls_pkg::SENSOR_COUNT-1:0] levels,
                                output rcls_pkg::result_type st);
      if (sample) begin
         apply_steering();
         charging = 1'b1;
         count    = '0;
         slot     = rcls_pkg::SLOT_FIRST;
         scanning = 1'b1;
      end else begin
         take_measure(levels);
      end
      st.line_drive  = charging;
      st.sensor_bits = black;
      st.left_dir    = motor.left_dir;
      st.right_dir   = motor.right_dir;
      st.left_duty   = motor.left_duty;
      st.right_duty  = motor.right_duty;
      st.scan_busy   = scanning;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         fails++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      rcls_pkg::result_type want;
      rcls_pkg::result_type got;
      if (reset) begin
         cfg      = {rcls_pkg::RST_THRESHOLD, rcls_pkg::RST_CHARGE, rcls_pkg::RST_OFFSET,
                     rcls_pkg::RST_LIMIT, rcls_pkg::RST_CLAMP};
         motor    = {rcls_pkg::DIR_STOP, rcls_pkg::DIR_FWD, 7'd0, 7'd0};
         black    = '0;
         slot     = rcls_pkg::SLOT_FIRST;
         count    = '0;
         charging = 1'b1;
         scanning = 1'b0;
         status_due.delete();
      end else begin
         // Track register writes, check read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  rcls_pkg::CSR_THRESHOLD:
                     cfg.black_threshold = csr_pwdata[rcls_pkg::THRESHOLD_WIDTH-1:0];
                  rcls_pkg::CSR_CHARGE:
                     cfg.charge_ticks    = csr_pwdata[rcls_pkg::CHARGE_WIDTH-1:0];
                  rcls_pkg::CSR_OFFSET:
                     cfg.duty_offset     = csr_pwdata[rcls_pkg::DUTY_WIDTH-1:0];
                  rcls_pkg::CSR_LIMIT:
                     cfg.duty_limit      = csr_pwdata[rcls_pkg::DUTY_WIDTH-1:0];
                  rcls_pkg::CSR_CLAMP:
                     cfg.duty_clamp      = csr_pwdata[rcls_pkg::DUTY_WIDTH-1:0];
                  default: ;
               endcase
            end else begin
               check_field("prdata", register_value(csr_paddr[4:2]), csr_prdata);
            end
         end

         // Compare a delivered status word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               fails++;
               $display("%0t: status word %h arrived with no tick pending, expected none",
                        $time, rsp_tdata);
            end else begin
               want = status_due.pop_front();
               got  = rsp_tdata[$bits(rcls_pkg::result_type)-1:0];
               check_field("line_drive", 32'(want.line_drive), 32'(got.line_drive));
               check_field("sensor_bits", 32'(want.sensor_bits), 32'(got.sensor_bits));
               check_field("left_dir", 32'(want.left_dir), 32'(got.left_dir));
               check_field("right_dir", 32'(want.right_dir), 32'(got.right_dir));
               check_field("left_duty", 32'(want.left_duty), 32'(got.left_duty));
               check_field("right_duty", 32'(want.right_duty), 32'(got.right_duty));
               check_field("scan_busy", 32'(want.scan_busy), 32'(got.scan_busy));
               check_field("padding", 32'd0,
                           32'(rsp_tdata[31:$bits(rcls_pkg::result_type)]));
               checked++;
            end
         end

         // Predict the status for an accepted tick
         if (req_tvalid && req_tready) begin
            step_steering(req_tuser, req_tdata[rcls_pkg::SENSOR_COUNT-1:0], want);
            status_due.push_back(want);
         end
      end
      fail_count    <= fails;
      pending_count <= status_due.size();
      checked_count <= checked;
   end

endmodule

// ----- verif/tb_rc_line_sensor_steering.sv -----
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the line sensor steering block.
module tb_rc_line_sensor_steering;

   localparam logic TICK_MEASURE   = 1'b0;
   localparam logic TICK_SAMPLE    = 1'b1;
   localparam int   PHASE_COUNT    = 8;
   localparam int   PHASE_TICKS    = 225;
   localparam int   DRAIN_CYCLES   = 8;
   localparam int   HOLD_CYCLES    = 400;
   localparam int   WATCHDOG_LIMIT = 3000;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_TX_GAPS, FLOW_RX_STALLS, FLOW_BOTH} flow_type;
   typedef logic [rcls_pkg::SENSOR_COUNT-1:0] levels_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [15:0]                         req_tdata = '0;  // [8:0] line_levels
   logic                                req_tuser = 1'b0;  // [0] func
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [0] line_drive, [9:1] sensor_bits, [11:10] left_dir, [13:12] right_dir,
   // [20:14] left_duty, [27:21] right_duty, [28] scan_busy
   logic [31:0]                         rsp_tdata;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [rcls_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [rcls_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   int fail_count;
   int pending_count;
   int checked_count;
   int tx_gap_pct = 0;
   int rx_stall_pct = 0;
   bit rx_hold_request = 1'b0;
   int ticks_sent = 0;
   int phase_left = 0;
   int quiet_cycles = 0;

   rc_line_sensor_steering u_top (.*);

   rcls_steering_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: random stalls, plus one long hold-off when asked
   initial begin : rx_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
         end
      end
   end

   // Abort when nothing moves on any port for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_rc_line_sensor_steering: done, errors");
         $finish;
      end
   end

   // Offer one tick word, with random gaps ahead of it, and hold until taken
   task automatic send_tick(input logic kind, input levels_type levels);
      while ($urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, levels};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ticks_sent++;
      phase_left--;
   endtask

   task automatic csr_access(input logic write, input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
      csr_access(1'b1, idx, value);
      csr_access(1'b0, idx, '0);
   endtask

   // Defaults, all-zero, then full threshold and charge with duties at 100, random ones after
   task automatic program_settings(input int ph);
      logic [31:0] thr, chg, ofs, lim, clp;
      case (ph)
         0: begin
            thr = 32'(rcls_pkg::RST_THRESHOLD); chg = 32'(rcls_pkg::RST_CHARGE);
            ofs = 32'(rcls_pkg::RST_OFFSET);    lim = 32'(rcls_pkg::RST_LIMIT);
            clp = 32'(rcls_pkg::RST_CLAMP);
         end
         1: begin
            thr = 0; chg = 0; ofs = 0; lim = 0; clp = 0;
         end
         2: begin
            thr = 255; chg = 15; ofs = 100; lim = 100; clp = 100;
         end
         default: begin
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            chg = $urandom_range(0, 15);
            ofs = $urandom_range(0, 100);
            lim = $urandom_range(0, 100);
            clp = $urandom_range(0, 100);
         end
      endcase
      set_register(rcls_pkg::CSR_THRESHOLD, thr);
      set_register(rcls_pkg::CSR_CHARGE, chg);
      set_register(rcls_pkg::CSR_OFFSET, ofs);
      set_register(rcls_pkg::CSR_LIMIT, lim);
      set_register(rcls_pkg::CSR_CLAMP, clp);
   endtask

   // Sample tick, then measure ticks whose lines drop at a per-line rate;
   // a held scan keeps every line high long enough to saturate the count
   task automatic run_scan(input bit held);
      int         rate [rcls_pkg::SENSOR_COUNT];
      int         span;
      int         stuck;
      levels_type levels;
      for (int b = 0; b < rcls_pkg::SENSOR_COUNT; b++) begin
         case ($urandom_range(0, 4))
            0:       rate[b] = 1;
            1:       rate[b] = 2;
            2:       rate[b] = 4;
            3:       rate[b] = 12;
            default: rate[b] = 40;
         endcase
      end
      stuck = held ? $urandom_range(275, 300) : 0;
      span  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(30, 160);
      span += stuck;
      send_tick(TICK_SAMPLE, levels_type'($urandom_range(0, 511)));
      for (int i = 0; i < span && (phase_left > 0 || i < stuck); i++) begin
         if (i < stuck) begin
            levels = '1;
         end else begin
            for (int b = 0; b < rcls_pkg::SENSOR_COUNT; b++)
               levels[b] = ($urandom_range(0, rate[b] - 1) != 0);
         end
         send_tick(TICK_MEASURE, levels);
      end
   endtask

   // Fully random words, stray sample ticks among them
   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n && phase_left > 0; i++)
         send_tick(($urandom_range(0, 3) == 0) ? TICK_SAMPLE : TICK_MEASURE,
                   levels_type'($urandom_range(0, 511)));
   endtask

   // Drop valid and wait until every status word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      flow_type flow;
      bit       first;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle ticks, a sample with nothing black, a quick all-white scan to its end
      send_tick(TICK_MEASURE, '0);
      send_tick(TICK_MEASURE, '1);
      send_tick(TICK_SAMPLE, '0);
      repeat (21) send_tick(TICK_MEASURE, '0);
      send_tick(TICK_SAMPLE, '1);
      drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         flow = flow_type'(ph % 4);
         case (flow)
            FLOW_FREE:      begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            FLOW_TX_GAPS:   begin tx_gap_pct = 67; rx_stall_pct = 0;  end
            FLOW_RX_STALLS: begin tx_gap_pct = 0;  rx_stall_pct = 67; end
            default:        begin tx_gap_pct = 22; rx_stall_pct = 22; end
         endcase
         program_settings(ph);
         // Back-pressure: result side holds off while words keep coming
         if (ph == 4)
            rx_hold_request = 1'b1;
         phase_left = PHASE_TICKS;
         first = 1'b1;
         while (phase_left > 0) begin
            if (!first && $urandom_range(0, 7) == 0)
               noise_burst();
            else
               run_scan(first && (ph == 3 || ph == 6));
            first = 1'b0;
         end
         drain();
      end

      $display("summary: %0d tick words over %0d register settings and four flow modes,",
               ticks_sent, PHASE_COUNT + 1);
      $display("summary: incl. a long result hold-off; %0d status words checked",
               checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_rc_line_sensor_steering: done, clean");
      else
         $display("tb_rc_line_sensor_steering: done, errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rcls_pkg.sv
rtl/rcls_csr.sv
rtl/rcls_steer.sv
rtl/rcls_core.sv
rtl/rc_line_sensor_steering.sv
verif/rcls_steering_checker.sv
verif/tb_rc_line_sensor_steering.sv
